[hdl/atrpm_pkg.sv]
// atrpm_pkg: shared types and constants of the modem response pattern matcher
// the fixed pattern characters, pattern lengths, pattern ids and pin level codes
// no dependencies
package atrpm_pkg;

    localparam int PAT_COUNT = 9;
    localparam int PAT_MAX   = 14;
    localparam int PROG_W    = 4;

    typedef logic [7:0]        char_t;
    typedef logic [PROG_W-1:0] prog_t;

    typedef enum logic [3:0] {
        PAT_OK     = 4'd0,
        PAT_READY  = 4'd1,
        PAT_PROMPT = 4'd2,
        PAT_CLOSED = 4'd3,
        PAT_HTTP   = 4'd4,
        PAT_IPD    = 4'd5,
        PAT_OFF    = 4'd6,
        PAT_LEVEL1 = 4'd7,
        PAT_LEVEL2 = 4'd8
    } pat_id_t;

    typedef logic [1:0] pin_level_t;
    localparam pin_level_t PIN_OFF    = 2'd0;
    localparam pin_level_t PIN_LEVEL1 = 2'd1;
    localparam pin_level_t PIN_LEVEL2 = 2'd2;

    localparam char_t CHAR_CR = 8'h0D;
    localparam char_t CHAR_LF = 8'h0A;
    localparam char_t CHAR_NUL = 8'h00;

    localparam char_t PAT_CHAR [PAT_COUNT][PAT_MAX] = '{
        '{0:"O", 1:"K", 2:CHAR_CR, 3:CHAR_LF, default:CHAR_NUL},
        '{0:"r", 1:"e", 2:"a", 3:"d", 4:"y", 5:CHAR_CR, 6:CHAR_LF, default:CHAR_NUL},
        '{0:"O", 1:"K", 2:CHAR_CR, 3:CHAR_LF, 4:">", default:CHAR_NUL},
        '{0:",", 1:"C", 2:"L", 3:"O", 4:"S", 5:"E", 6:"D", 7:CHAR_CR, 8:CHAR_LF,
          default:CHAR_NUL},
        '{0:"G", 1:"E", 2:"T", 3:" ", 4:"/", 5:" ", 6:"H", 7:"T", 8:"T", 9:"P",
          10:"/", 11:"1", 12:".", 13:"1"},
        '{0:"+", 1:"I", 2:"P", 3:"D", 4:",", default:CHAR_NUL},
        '{0:"G", 1:"E", 2:"T", 3:" ", 4:"/", 5:"?", 6:"p", 7:"i", 8:"n", 9:"=",
          10:"T", 11:"A", 12:"T", default:CHAR_NUL},
        '{0:"G", 1:"E", 2:"T", 3:" ", 4:"/", 5:"?", 6:"p", 7:"i", 8:"n", 9:"=",
          10:"M", 11:"U", 12:"C", 13:"1"},
        '{0:"G", 1:"E", 2:"T", 3:" ", 4:"/", 5:"?", 6:"p", 7:"i", 8:"n", 9:"=",
          10:"M", 11:"U", 12:"C", 13:"2"}
    };

    localparam prog_t PAT_LEN [PAT_COUNT] = '{
        4'd4, 4'd7, 4'd5, 4'd9, 4'd14, 4'd5, 4'd13, 4'd14, 4'd14
    };

endpackage

[hdl/atrpm_stream_if.sv]
// atrpm_rx_if and atrpm_res_if: valid/ready channels of the pattern matcher
// depends on nothing but plain logic types
interface atrpm_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atrpm_res_if;
    logic       valid;
    logic       ready;
    logic       ok_found;
    logic       ready_found;
    logic       prompt_found;
    logic       closed_found;
    logic       http_found;
    logic       ipd_found;
    logic [7:0] link_id;
    logic       link_id_captured;
    logic [1:0] pin_level;
    logic       pin_changed;
    logic       refresh_request;

    modport source (
        output valid, input ready,
        output ok_found, output ready_found, output prompt_found, output closed_found,
        output http_found, output ipd_found, output link_id, output link_id_captured,
        output pin_level, output pin_changed, output refresh_request
    );
    modport sink (
        input valid, output ready,
        input ok_found, input ready_found, input prompt_found, input closed_found,
        input http_found, input ipd_found, input link_id, input link_id_captured,
        input pin_level, input pin_changed, input refresh_request
    );
endinterface

[hdl/atrpm_matcher_bank.sv]
// atrpm_matcher_bank: nine fixed-pattern matchers with their progress counters
// depends on atrpm_pkg for the pattern characters and lengths
module atrpm_matcher_bank (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  atrpm_pkg::char_t                   rx_byte,
    output logic [atrpm_pkg::PAT_COUNT-1:0]    found
);

    atrpm_pkg::prog_t prog_reg  [atrpm_pkg::PAT_COUNT];
    atrpm_pkg::prog_t prog_next [atrpm_pkg::PAT_COUNT];

    for (genvar p = 0; p < atrpm_pkg::PAT_COUNT; p++) begin : g_pat
        logic hit;
        logic last;

        // a counter out of range counts as a mismatch
        assign hit  = (prog_reg[p] < atrpm_pkg::PAT_LEN[p])
                   && (rx_byte == atrpm_pkg::PAT_CHAR[p][prog_reg[p]]);
        assign last = (prog_reg[p] == atrpm_pkg::PAT_LEN[p] - atrpm_pkg::prog_t'(1));

        assign found[p]     = hit && last;
        // mismatch restarts at zero without re-checking the first character
        assign prog_next[p] = (hit && !last) ? prog_reg[p] + atrpm_pkg::prog_t'(1)
                                             : '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                prog_reg[p] <= '0;
            end
            else if (step)
            begin
                prog_reg[p] <= prog_next[p];
            end
        end
    end

endmodule

[hdl/at_response_pattern_matcher_core.sv]
// at_response_pattern_matcher_core: top level of the modem response matcher
// depends on atrpm_pkg, atrpm_rx_if, atrpm_res_if and atrpm_matcher_bank
//
// Received modem bytes arrive one per transfer on rx and each produces exactly one
// result transfer on res, in order. Nine matchers (OK, ready, OK prompt, CLOSED,
// HTTP GET, +IPD and the three pin commands) run side by side; a mismatching byte
// restarts a matcher at zero and is not re-checked against the first character.
// The byte after "+IPD," is held as the link id, the pin commands set the held pin
// level, and an HTTP request or pin command raises refresh_request. A byte passes
// from the input register through the matcher logic into the result register. One
// byte is taken every cycle while res keeps up; the input register and the result
// register form a two-deep pipeline, so a byte is still accepted while a finished
// result waits.
module at_response_pattern_matcher_core (
    input  logic               clk,
    input  logic               rst_n,
    atrpm_rx_if.sink           rx,
    atrpm_res_if.source        res
);

    // input register
    logic                  in_valid_reg;
    atrpm_pkg::char_t      in_byte_reg;

    // result register
    logic                  res_valid_reg;
    logic [atrpm_pkg::PAT_COUNT-1:0] found_reg;
    logic                  captured_reg;
    logic                  pin_changed_reg;

    // matcher side state
    logic                  pending_reg;
    logic                  pending_next;
    atrpm_pkg::char_t      link_id_reg;
    atrpm_pkg::char_t      link_id_next;
    atrpm_pkg::pin_level_t pin_level_reg;
    atrpm_pkg::pin_level_t pin_level_next;
    logic                  pin_changed_next;

    logic                  step;
    logic [atrpm_pkg::PAT_COUNT-1:0] found;

    // the held byte moves to the result register when that register is free or drained
    assign step     = in_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || step;

    atrpm_matcher_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .found   (found)
    );

    // link id capture happens before the +IPD matcher sees the byte
    always_comb
    begin
        link_id_next = pending_reg ? in_byte_reg : link_id_reg;
        pending_next = found[atrpm_pkg::PAT_IPD];
    end

    // pin commands, later one wins
    always_comb
    begin
        pin_level_next   = pin_level_reg;
        pin_changed_next = 1'b0;
        if (found[atrpm_pkg::PAT_OFF])
        begin
            pin_level_next   = atrpm_pkg::PIN_OFF;
            pin_changed_next = 1'b1;
        end
        if (found[atrpm_pkg::PAT_LEVEL1])
        begin
            pin_level_next   = atrpm_pkg::PIN_LEVEL1;
            pin_changed_next = 1'b1;
        end
        if (found[atrpm_pkg::PAT_LEVEL2])
        begin
            pin_level_next   = atrpm_pkg::PIN_LEVEL2;
            pin_changed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_byte_reg     <= '0;
            res_valid_reg   <= 1'b0;
            found_reg       <= '0;
            captured_reg    <= 1'b0;
            pin_changed_reg <= 1'b0;
            pending_reg     <= 1'b0;
            link_id_reg     <= '0;
            pin_level_reg   <= atrpm_pkg::PIN_OFF;
        end
        else
        begin
            // input side
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= rx.rx_byte;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            // result side
            if (step)
            begin
                res_valid_reg   <= 1'b1;
                found_reg       <= found;
                captured_reg    <= pending_reg;
                pin_changed_reg <= pin_changed_next;
                pending_reg     <= pending_next;
                link_id_reg     <= link_id_next;
                pin_level_reg   <= pin_level_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.ok_found         = found_reg[atrpm_pkg::PAT_OK];
    assign res.ready_found      = found_reg[atrpm_pkg::PAT_READY];
    assign res.prompt_found     = found_reg[atrpm_pkg::PAT_PROMPT];
    assign res.closed_found     = found_reg[atrpm_pkg::PAT_CLOSED];
    assign res.http_found       = found_reg[atrpm_pkg::PAT_HTTP];
    assign res.ipd_found        = found_reg[atrpm_pkg::PAT_IPD];
    assign res.link_id          = link_id_reg;
    assign res.link_id_captured = captured_reg;
    assign res.pin_level        = pin_level_reg;
    assign res.pin_changed      = pin_changed_reg;
    assign res.refresh_request  = found_reg[atrpm_pkg::PAT_HTTP] | pin_changed_reg;

endmodule

[dv/atrpm_match_checker.sv]
// atrpm_match_checker: watches the rx and res channels of the pattern matcher core,
// predicts every result from the accepted bytes and compares it field by field
// depends on atrpm_pkg, atrpm_rx_if and atrpm_res_if
module atrpm_match_checker (
    input  logic  clk,
    input  logic  rst_n,
    atrpm_rx_if   rx,
    atrpm_res_if  res,
    output int    mismatches,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                  ok_found;
        logic                  ready_found;
        logic                  prompt_found;
        logic                  closed_found;
        logic                  http_found;
        logic                  ipd_found;
        logic [7:0]            link_id;
        logic                  link_id_captured;
        atrpm_pkg::pin_level_t pin_level;
        logic                  pin_changed;
        logic                  refresh_request;
    } match_result_t;

    logic [3:0]            progress [atrpm_pkg::PAT_COUNT];
    logic                  capture_pending;
    logic [7:0]            held_link_id;
    atrpm_pkg::pin_level_t held_pin_level;
    match_result_t         awaited_results [$];
    int                    result_count;

    function automatic string pattern_text(input atrpm_pkg::pat_id_t id);
        case (id)
            atrpm_pkg::PAT_OK:     return "OK\015\012";
            atrpm_pkg::PAT_READY:  return "ready\015\012";
            atrpm_pkg::PAT_PROMPT: return "OK\015\012>";
            atrpm_pkg::PAT_CLOSED: return ",CLOSED\015\012";
            atrpm_pkg::PAT_HTTP:   return "GET / HTTP/1.1";
            atrpm_pkg::PAT_IPD:    return "+IPD,";
            atrpm_pkg::PAT_OFF:    return "GET /?pin=TAT";
            atrpm_pkg::PAT_LEVEL1: return "GET /?pin=MUC1";
            default:               return "GET /?pin=MUC2";
        endcase
    endfunction

    // a mismatching byte clears the counter without being tried as a first character
    function automatic logic step_matcher(input atrpm_pkg::pat_id_t id, input logic [7:0] b);
        string      text;
        logic [3:0] p;
        text = pattern_text(id);
        p = progress[id];
        if (int'(p) < text.len() && b == text[int'(p)])
        begin
            if (int'(p) + 1 == text.len())
            begin
                progress[id] = '0;
                return 1'b1;
            end
            progress[id] = p + 4'd1;
            return 1'b0;
        end
        progress[id] = '0;
        return 1'b0;
    endfunction

    function automatic match_result_t match_byte(input logic [7:0] b);
        match_result_t r;
        logic          off_hit;
        logic          lv1_hit;
        logic          lv2_hit;
        r = '0;
        r.ok_found     = step_matcher(atrpm_pkg::PAT_OK, b);
        r.ready_found  = step_matcher(atrpm_pkg::PAT_READY, b);
        r.prompt_found = step_matcher(atrpm_pkg::PAT_PROMPT, b);
        r.closed_found = step_matcher(atrpm_pkg::PAT_CLOSED, b);
        r.http_found   = step_matcher(atrpm_pkg::PAT_HTTP, b);
        // the pending capture takes this byte before the +IPD matcher sees it
        if (capture_pending)
        begin
            capture_pending = 1'b0;
            held_link_id = b;
            r.link_id_captured = 1'b1;
        end
        r.ipd_found = step_matcher(atrpm_pkg::PAT_IPD, b);
        if (r.ipd_found)
            capture_pending = 1'b1;
        off_hit = step_matcher(atrpm_pkg::PAT_OFF, b);
        lv1_hit = step_matcher(atrpm_pkg::PAT_LEVEL1, b);
        lv2_hit = step_matcher(atrpm_pkg::PAT_LEVEL2, b);
        if (off_hit)
            held_pin_level = atrpm_pkg::PIN_OFF;
        if (lv1_hit)
            held_pin_level = atrpm_pkg::PIN_LEVEL1;
        if (lv2_hit)
            held_pin_level = atrpm_pkg::PIN_LEVEL2;
        r.pin_changed     = off_hit | lv1_hit | lv2_hit;
        r.link_id         = held_link_id;
        r.pin_level       = held_pin_level;
        r.refresh_request = r.http_found | r.pin_changed;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d want %0d",
                 result_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            log_mismatch(what, int'(got), int'(want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        match_result_t want;
        if (!rst_n)
        begin
            foreach (progress[i])
                progress[i] = '0;
            capture_pending = 1'b0;
            held_link_id = '0;
            held_pin_level = atrpm_pkg::PIN_OFF;
            awaited_results.delete();
            result_count = 0;
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            // a result can never belong to a byte taken on the same edge
            if (res.valid && res.ready)
            begin
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    log_mismatch("result with nothing awaited", 0, 0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("ok_found", res.ok_found, want.ok_found);
                    check_field("ready_found", res.ready_found, want.ready_found);
                    check_field("prompt_found", res.prompt_found, want.prompt_found);
                    check_field("closed_found", res.closed_found, want.closed_found);
                    check_field("http_found", res.http_found, want.http_found);
                    check_field("ipd_found", res.ipd_found, want.ipd_found);
                    check_field("link_id", res.link_id, want.link_id);
                    check_field("link_id_captured", res.link_id_captured,
                                want.link_id_captured);
                    check_field("pin_level", res.pin_level, want.pin_level);
                    check_field("pin_changed", res.pin_changed, want.pin_changed);
                    check_field("refresh_request", res.refresh_request,
                                want.refresh_request);
                end
            end
            if (rx.valid && rx.ready)
                awaited_results.push_back(match_byte(rx.rx_byte));
            pending <= awaited_results.size();
        end
    end

endmodule

[dv/testbench.sv]
// testbench: top of the modem pattern matcher bench, makes clock, reset and byte traffic
// and gives the verdict from the mismatch count of the checker
// depends on atrpm_pkg, atrpm_rx_if, atrpm_res_if, atrpm_match_checker and the core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 750;
    localparam int GAP_PCT      = 28;
    localparam int STALL_LIMIT  = 1000;   // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES = 8;      // margin to drain the input and result registers

    logic        clk;
    logic        rst_n;
    bit          steady;        // set for a stretch where neither side idles
    int          items_sent;
    int unsigned quiet_cycles;
    int          mismatches;
    int          pending;

    atrpm_rx_if  rx_ch ();
    atrpm_res_if res_ch ();

    at_response_pattern_matcher_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    atrpm_match_checker match_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side stalls at random, except during the steady stretch
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= steady || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // watchdog: any transfer on either channel counts as progress
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // stimulus texts: the nine patterns as the modem or a browser would send them
    function automatic string command_text(input atrpm_pkg::pat_id_t id);
        case (id)
            atrpm_pkg::PAT_OK:     return "OK\015\012";
            atrpm_pkg::PAT_READY:  return "ready\015\012";
            atrpm_pkg::PAT_PROMPT: return "OK\015\012>";
            atrpm_pkg::PAT_CLOSED: return ",CLOSED\015\012";
            atrpm_pkg::PAT_HTTP:   return "GET / HTTP/1.1";
            atrpm_pkg::PAT_IPD:    return "+IPD,";
            atrpm_pkg::PAT_OFF:    return "GET /?pin=TAT";
            atrpm_pkg::PAT_LEVEL1: return "GET /?pin=MUC1";
            default:               return "GET /?pin=MUC2";
        endcase
    endfunction

    // noise: half full-range bytes, half characters the patterns are made of
    function automatic logic [7:0] noise_byte();
        string charset;
        charset = "OKready,CLOSED\015\012>GET /HTP1.?pin=AMUC2+I";
        if ($urandom_range(1))
            return 8'($urandom_range(255));
        return charset[$urandom_range(charset.len() - 1)];
    endfunction

    // one byte transfer on rx, with random idle cycles ahead of it outside the steady stretch;
    // idle cycles also scramble the byte lines while valid is low
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < GAP_PCT)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom_range(255));
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // broken sequence: a prefix, then either the first character again (a restart
    // that must not be re-checked) or a random byte
    task automatic send_damaged(input string s);
        int cut;
        cut = $urandom_range(s.len() - 1);
        for (int i = 0; i < cut; i++)
            send_byte(s[i]);
        if ($urandom_range(1))
            send_byte(s[0]);
        else
            send_byte(noise_byte());
    endtask

    initial
    begin
        atrpm_pkg::pat_id_t pick;
        int unsigned        roll;
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        steady         = 1'b0;
        items_sent     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        // OK and OK prompt overlap on the same bytes
        send_text("OK\015\012>");
        // a repeated first character is not taken as a restart
        send_text("OOK\015\012");
        // the byte after +IPD, is captured and still feeds the +IPD matcher
        send_text("+IPD,+IPD,Z");

        // random: mostly whole patterns, some broken, some noise
        while (items_sent < ITEM_TARGET)
        begin
            steady = (items_sent >= 300 && items_sent < 420);
            pick = atrpm_pkg::pat_id_t'($urandom_range(atrpm_pkg::PAT_COUNT - 1));
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                send_text(command_text(pick));
                // usually a link id follows; without one the next text's first byte is taken
                if (pick == atrpm_pkg::PAT_IPD && $urandom_range(3) != 0)
                    send_byte(8'($urandom_range(255)));
            end
            else if (roll < 85)
                send_damaged(command_text(pick));
            else
                repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        end
        rx_ch.valid <= 1'b0;

        // let the checker see the last transfer, then drain the pipeline
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
